### hdl/coverage_tiered_min_error_select_unit_defines.svh
// Assertion macros shared by the coverage tiered select unit.
// Depends on nothing; expects signals named clock and reset in the including module.
`ifndef COVERAGE_TIERED_MIN_ERROR_SELECT_UNIT_DEFINES_SVH
`define COVERAGE_TIERED_MIN_ERROR_SELECT_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define CTMES_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define CTMES_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### hdl/ctmes_pkg.sv
// Shared constants and control types for the coverage tiered select unit.
// No dependencies.
package ctmes_pkg;

   localparam int MAX_ENTRIES = 1024;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int COV_W       = 17;
   localparam int RATE_W      = 24;
   localparam int INDEX_W     = 10;
   localparam int SLOT_W      = 4;
   localparam int LAST_SLOT   = 9;
   localparam int HALF_COV    = 32768;
   // 9 * coverage fits in four more bits
   localparam int BOUND_W     = COV_W + 4;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic store;       // write the accepted item into the store
      logic rd_max;      // read the max-coverage entry, latch thresholds
      logic init_best;   // seed all picks from the max-coverage entry
      logic scan_issue;  // read the next entry of the replay pass
      logic clear;       // end of list, drop the list state
   } ctmes_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic scan_last;   // the entry read now is the last one of the list
   } ctmes_status_type;

endpackage

### hdl/ctmes_if.sv
// Valid/ready channel interfaces for entries in and selected indexes out.
// Depends on ctmes_pkg.
interface ctmes_req_if;
   logic                         valid;
   logic                         ready;
   logic [ctmes_pkg::COV_W-1:0]  coverage;
   logic [ctmes_pkg::RATE_W-1:0] error_rate;
   logic                         last_entry;

   modport source (output valid, output coverage, output error_rate, output last_entry,
                   input ready);
   modport sink   (input valid, input coverage, input error_rate, input last_entry,
                   output ready);
endinterface

interface ctmes_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ctmes_pkg::SLOT_W-1:0]  slot;
   logic [ctmes_pkg::INDEX_W-1:0] entry_index;
   logic                          last_result;

   modport source (output valid, output slot, output entry_index, output last_result,
                   input ready);
   modport sink   (input valid, input slot, input entry_index, input last_result,
                   output ready);
endinterface

### hdl/coverage_tiered_min_error_select_unit.sv
// Entries load at one per cycle while ready is high. After the final entry of a list of N
// entries, setup and the replay scan run before the first result is offered; ten results
// then leave at one per cycle while the sink takes them. The scan length is set by the
// single read port of the entry store. Reset (synchronous) clears the sequencer and the
// list state; the entry stores are not cleared.
// Depends on ctmes_pkg, ctmes_if, ctmes_ctrl and ctmes_datapath.
module coverage_tiered_min_error_select_unit (
   input  logic        clock,
   input  logic        reset,
   ctmes_req_if.sink   req_if,
   ctmes_rsp_if.source rsp_if
);

   ctmes_pkg::ctmes_cmd_type     cmd;
   ctmes_pkg::ctmes_status_type  status;
   logic [ctmes_pkg::SLOT_W-1:0] slot;

   // Sequence the list
   ctmes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_entry),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_slot  (slot),
      .rsp_last  (rsp_if.last_result),
      .cmd       (cmd),
      .status    (status)
   );

   // Store entries and run the searches
   ctmes_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_coverage    (req_if.coverage),
      .req_error_rate  (req_if.error_rate),
      .rsp_slot        (slot),
      .rsp_entry_index (rsp_if.entry_index)
   );

   assign rsp_if.slot = slot;

endmodule

### hdl/ctmes_ctrl.sv
// Sequencer for load, threshold scan and result emission.
// Depends on ctmes_pkg and the assertion macro header.
`include "coverage_tiered_min_error_select_unit_defines.svh"

module ctmes_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_last,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ctmes_pkg::SLOT_W-1:0] rsp_slot,
   output logic                         rsp_last,
   output ctmes_pkg::ctmes_cmd_type     cmd,
   input  ctmes_pkg::ctmes_status_type  status
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_INIT,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   state_type                    state_ff;
   logic                         ready_ff;
   logic                         valid_ff;
   logic [ctmes_pkg::SLOT_W-1:0] slot_ff;
   logic                         in_take;
   logic                         out_take;
   logic                         final_slot;

   assign in_take    = req_valid && ready_ff;
   assign out_take   = valid_ff && rsp_ready;
   assign final_slot = (slot_ff == ctmes_pkg::SLOT_W'(ctmes_pkg::LAST_SLOT));

   // Decode commands
   always_comb begin
      cmd            = '0;
      cmd.store      = in_take;
      cmd.rd_max     = (state_ff == ST_FETCH);
      cmd.init_best  = (state_ff == ST_INIT);
      cmd.scan_issue = (state_ff == ST_INIT) || (state_ff == ST_SCAN);
      cmd.clear      = out_take && final_slot;
   end

   // Advance state, hold ready/valid/slot registered
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         ready_ff <= 1'b1;
         valid_ff <= 1'b0;
         slot_ff  <= '0;
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (in_take && req_last) begin
                  state_ff <= ST_FETCH;
                  ready_ff <= 1'b0;
               end
            end
            ST_FETCH: begin
               state_ff <= ST_INIT;
            end
            ST_INIT, ST_SCAN: begin
               if (status.scan_last) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_EMIT;
               valid_ff <= 1'b1;
               slot_ff  <= '0;
            end
            ST_EMIT: begin
               if (out_take) begin
                  if (final_slot) begin
                     state_ff <= ST_LOAD;
                     valid_ff <= 1'b0;
                     ready_ff <= 1'b1;
                  end else begin
                     slot_ff <= slot_ff + ctmes_pkg::SLOT_W'(1);
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
               ready_ff <= 1'b1;
               valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready = ready_ff;
   assign rsp_valid = valid_ff;
   assign rsp_slot  = slot_ff;
   assign rsp_last  = final_slot;

   `CTMES_ASSERT_ALWAYS(a_no_overlap, reset || !(ready_ff && valid_ff), "load and emit overlap")
   `CTMES_ASSERT(a_slot_range, !valid_ff || (slot_ff <= ctmes_pkg::SLOT_W'(ctmes_pkg::LAST_SLOT)),
      "slot beyond last")
   `CTMES_ASSERT(a_reopen, (out_take && final_slot) |=> (ready_ff && !valid_ff),
      "list not reopened after last result")

endmodule

### hdl/ctmes_datapath.sv
// Entry stores, list maximum, nine parallel threshold searches and result index mux.
// Depends on ctmes_pkg and the assertion macro header.
`include "coverage_tiered_min_error_select_unit_defines.svh"

module ctmes_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  ctmes_pkg::ctmes_cmd_type      cmd,
   output ctmes_pkg::ctmes_status_type   status,
   input  logic [ctmes_pkg::COV_W-1:0]   req_coverage,
   input  logic [ctmes_pkg::RATE_W-1:0]  req_error_rate,
   input  logic [ctmes_pkg::SLOT_W-1:0]  rsp_slot,
   output logic [ctmes_pkg::INDEX_W-1:0] rsp_entry_index
);

   logic [ctmes_pkg::COV_W-1:0]   cov_mem_ff  [ctmes_pkg::MAX_ENTRIES];
   logic [ctmes_pkg::RATE_W-1:0]  rate_mem_ff [ctmes_pkg::MAX_ENTRIES];

   logic [ctmes_pkg::CNT_W-1:0]   count_ff;
   logic [ctmes_pkg::COV_W-1:0]   max_ff;
   logic [ctmes_pkg::ADDR_W-1:0]  max_idx_ff;
   logic                          have_max_ff;

   logic [ctmes_pkg::ADDR_W-1:0]  scan_ff;
   logic [ctmes_pkg::ADDR_W-1:0]  cmp_idx_ff;
   logic                          cmp_pend_ff;
   logic [ctmes_pkg::COV_W-1:0]   rd_cov_ff;
   logic [ctmes_pkg::RATE_W-1:0]  rd_rate_ff;

   logic [ctmes_pkg::BOUND_W-1:0] bound_ff     [1:ctmes_pkg::LAST_SLOT];
   logic [ctmes_pkg::RATE_W-1:0]  best_rate_ff [1:ctmes_pkg::LAST_SLOT];
   logic [ctmes_pkg::ADDR_W-1:0]  best_idx_ff  [1:ctmes_pkg::LAST_SLOT];

   logic                          room;
   logic                          do_write;
   logic [ctmes_pkg::ADDR_W-1:0]  rd_addr;
   logic [ctmes_pkg::BOUND_W-1:0] cov9;
   logic                          ge_half;

   assign room     = (count_ff < ctmes_pkg::CNT_W'(ctmes_pkg::MAX_ENTRIES));
   assign do_write = cmd.store && room;
   assign rd_addr  = cmd.rd_max ? max_idx_ff : scan_ff;
   assign cov9     = ctmes_pkg::BOUND_W'({rd_cov_ff, 3'b000}) + ctmes_pkg::BOUND_W'(rd_cov_ff);
   assign ge_half  = (max_ff >= ctmes_pkg::COV_W'(ctmes_pkg::HALF_COV));

   assign status.scan_last =
      ((ctmes_pkg::CNT_W'(scan_ff) + ctmes_pkg::CNT_W'(1)) == count_ff);

   // Write the stores, register the read port
   always_ff @(posedge clock) begin
      if (do_write) begin
         cov_mem_ff[count_ff[ctmes_pkg::ADDR_W-1:0]]  <= req_coverage;
         rate_mem_ff[count_ff[ctmes_pkg::ADDR_W-1:0]] <= req_error_rate;
      end
      rd_cov_ff  <= cov_mem_ff[rd_addr];
      rd_rate_ff <= rate_mem_ff[rd_addr];
   end

   // Track fill count and first maximum
   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff    <= '0;
         max_ff      <= '0;
         max_idx_ff  <= '0;
         have_max_ff <= 1'b0;
      end else if (do_write) begin
         count_ff <= count_ff + ctmes_pkg::CNT_W'(1);
         if (!have_max_ff || (req_coverage > max_ff)) begin
            max_ff      <= req_coverage;
            max_idx_ff  <= count_ff[ctmes_pkg::ADDR_W-1:0];
            have_max_ff <= 1'b1;
         end
      end
   end

   // Step the replay address, mark the compare in the cycle after the read is issued
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         cmp_pend_ff <= 1'b0;
      end else begin
         cmp_pend_ff <= cmd.scan_issue;
         if (cmd.rd_max) begin
            scan_ff <= '0;
         end else if (cmd.scan_issue) begin
            scan_ff <= scan_ff + ctmes_pkg::ADDR_W'(1);
         end
      end
      cmp_idx_ff <= scan_ff;
   end

   // Latch thresholds: (9-k)*max + k*half
   always_ff @(posedge clock) begin
      if (cmd.rd_max) begin
         for (int k = 1; k <= ctmes_pkg::LAST_SLOT; k++) begin
            bound_ff[k] <= ctmes_pkg::BOUND_W'(max_ff) *
                              ctmes_pkg::BOUND_W'(ctmes_pkg::LAST_SLOT - k) +
                           ctmes_pkg::BOUND_W'(k) * ctmes_pkg::BOUND_W'(ctmes_pkg::HALF_COV);
         end
      end
   end

   // Seed picks, then keep the strictly lower rate among qualifying entries
   always_ff @(posedge clock) begin
      for (int k = 1; k <= ctmes_pkg::LAST_SLOT; k++) begin
         if (cmd.init_best) begin
            best_rate_ff[k] <= rd_rate_ff;
            best_idx_ff[k]  <= max_idx_ff;
         end else if (cmp_pend_ff && (cov9 >= bound_ff[k]) && (rd_rate_ff < best_rate_ff[k]))
         begin
            best_rate_ff[k] <= rd_rate_ff;
            best_idx_ff[k]  <= cmp_idx_ff;
         end
      end
   end

   // Select the index for the slot on the output
   always_comb begin
      if ((rsp_slot == '0) || !ge_half) begin
         rsp_entry_index = ctmes_pkg::INDEX_W'(max_idx_ff);
      end else begin
         rsp_entry_index = ctmes_pkg::INDEX_W'(best_idx_ff[rsp_slot]);
      end
   end

   `CTMES_ASSERT(a_count_bound, count_ff <= ctmes_pkg::CNT_W'(ctmes_pkg::MAX_ENTRIES),
      "fill count beyond store depth")
   `CTMES_ASSERT(a_max_seen, have_max_ff == (count_ff != '0), "max flag out of step with count")
   `CTMES_ASSERT(a_cmp_follows, cmp_pend_ff |-> $past(cmd.scan_issue), "compare without a read")

endmodule
